// ----- rtl/bilinear_interpolator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// bilinear interpolator assertion macros
// shared property forms for the pipeline checks
// ----------------------------------------------------------------------------
`ifndef BILINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define BILINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilinear interpolator check failed");

// next-cycle implication
`define BI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bilinear interpolator check failed");

`endif

// ----- rtl/bi_pkg.sv -----
// ----------------------------------------------------------------------------
// bi_pkg
// coordinate widths and types shared by the interpolator pipeline
// ----------------------------------------------------------------------------
package bi_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

endpackage

// ----- rtl/bi_prep.sv -----
// ----------------------------------------------------------------------------
// bi_prep
// first-axis differences and the two row numerator products, two stages
// ----------------------------------------------------------------------------
module bi_prep #(
  parameter int VALUE_WIDTH = 16,
  parameter int NUM_WIDTH   = 34
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bi_pkg::coord_t                      in_query_x,
  input  bi_pkg::coord_t                      in_query_y,
  input  bi_pkg::coord_t                      in_cell_x_low,
  input  bi_pkg::coord_t                      in_cell_x_high,
  input  bi_pkg::coord_t                      in_cell_y_low,
  input  bi_pkg::coord_t                      in_cell_y_high,
  input  logic signed [VALUE_WIDTH-1:0]       in_corner_a_low,
  input  logic signed [VALUE_WIDTH-1:0]       in_corner_a_high,
  input  logic signed [VALUE_WIDTH-1:0]       in_corner_b_low,
  input  logic signed [VALUE_WIDTH-1:0]       in_corner_b_high,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0][NUM_WIDTH-1:0]           out_num,
  output bi_pkg::diff_t                       out_span_x,
  output bi_pkg::diff_t                       out_dp_y,
  output bi_pkg::diff_t                       out_span_y,
  output logic [VALUE_WIDTH-1:0]              out_base_a,
  output logic [VALUE_WIDTH-1:0]              out_base_b,
  output logic                                out_zero
);
  import bi_pkg::*;

  logic [1:0] v_r;
  logic [2:0] adv;

  diff_t                        dpx_r, spx_r, dpy_r, spy_r;
  logic signed [VALUE_WIDTH:0]  dqa_r, dqb_r;
  logic [VALUE_WIDTH-1:0]       a0_r, b0_r;
  logic                         zero_r;

  logic [1:0][NUM_WIDTH-1:0]    num_r;
  diff_t                        spx1_r, dpy1_r, spy1_r;
  logic [VALUE_WIDTH-1:0]       a01_r, b01_r;
  logic                         zero1_r;

  logic signed [NUM_WIDTH-1:0]  prod_a, prod_b;

  always_comb begin
    adv[2] = out_ready;
    adv[1] = ~v_r[1] | adv[2];
    adv[0] = ~v_r[0] | adv[1];
  end

  assign in_ready = adv[0];

  always_comb begin
    prod_a = dpx_r * dqa_r;
    prod_b = dpx_r * dqb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      if (adv[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dpx_r  <= {in_query_x[COORD_W-1], in_query_x} - {in_cell_x_low[COORD_W-1], in_cell_x_low};
      spx_r  <= {in_cell_x_high[COORD_W-1], in_cell_x_high}
              - {in_cell_x_low[COORD_W-1], in_cell_x_low};
      dpy_r  <= {in_query_y[COORD_W-1], in_query_y} - {in_cell_y_low[COORD_W-1], in_cell_y_low};
      spy_r  <= {in_cell_y_high[COORD_W-1], in_cell_y_high}
              - {in_cell_y_low[COORD_W-1], in_cell_y_low};
      dqa_r  <= {in_corner_a_high[VALUE_WIDTH-1], in_corner_a_high}
              - {in_corner_a_low[VALUE_WIDTH-1], in_corner_a_low};
      dqb_r  <= {in_corner_b_high[VALUE_WIDTH-1], in_corner_b_high}
              - {in_corner_b_low[VALUE_WIDTH-1], in_corner_b_low};
      a0_r   <= in_corner_a_low;
      b0_r   <= in_corner_b_low;
      zero_r <= (in_cell_x_high == in_cell_x_low) || (in_cell_y_high == in_cell_y_low);
    end
    if (adv[1]) begin
      num_r[0] <= prod_a;
      num_r[1] <= prod_b;
      spx1_r   <= spx_r;
      dpy1_r   <= dpy_r;
      spy1_r   <= spy_r;
      a01_r    <= a0_r;
      b01_r    <= b0_r;
      zero1_r  <= zero_r;
    end
  end

  assign out_valid  = v_r[1];
  assign out_num    = num_r;
  assign out_span_x = spx1_r;
  assign out_dp_y   = dpy1_r;
  assign out_span_y = spy1_r;
  assign out_base_a = a01_r;
  assign out_base_b = b01_r;
  assign out_zero   = zero1_r;

endmodule

// ----- rtl/bi_div.sv -----
// ----------------------------------------------------------------------------
// bi_div
// pipelined signed divider, one quotient bit per stage, truncating to zero
// ----------------------------------------------------------------------------
`include "bilinear_interpolator_unit_macros.svh"

module bi_div #(
  parameter int VALUE_WIDTH = 16,
  parameter int NUM_WIDTH   = 34,
  parameter int LANES       = 1,
  parameter int SIDE_WIDTH  = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [LANES-1:0][NUM_WIDTH-1:0]       in_num,
  input  bi_pkg::diff_t                         in_den,
  input  logic [SIDE_WIDTH-1:0]                 in_side,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [LANES-1:0][VALUE_WIDTH-1:0]     out_quot,
  output logic [SIDE_WIDTH-1:0]                 out_side
);
  import bi_pkg::*;

  localparam int STAGES = NUM_WIDTH + 2;
  localparam int LAST   = STAGES - 1;

  logic [STAGES-1:0]               v_r;
  logic [STAGES:0]                 adv;
  logic [DIFF_W-1:0]               den_r  [NUM_WIDTH+1];
  logic [DIFF_W-1:0]               rem_r  [NUM_WIDTH+1][LANES];
  logic [NUM_WIDTH-1:0]            nq_r   [NUM_WIDTH+1][LANES];
  logic                            sg_r   [NUM_WIDTH+1][LANES];
  logic [SIDE_WIDTH-1:0]           side_r [STAGES];
  logic [LANES-1:0][VALUE_WIDTH-1:0] quot_r;

  logic [DIFF_W-1:0]               rem_nxt [NUM_WIDTH][LANES];
  logic [NUM_WIDTH-1:0]            nq_nxt  [NUM_WIDTH][LANES];
  logic [NUM_WIDTH-1:0]            num_mag [LANES];
  logic [DIFF_W-1:0]               den_mag;

  always_comb begin
    adv[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = ~v_r[k] | adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[LAST];
  assign out_quot  = quot_r;
  assign out_side  = side_r[LAST];

  always_comb begin
    den_mag = in_den[DIFF_W-1] ? (~in_den + 1'b1) : in_den;
    for (int l = 0; l < LANES; l++) begin
      num_mag[l] = in_num[l][NUM_WIDTH-1] ? (~in_num[l] + 1'b1) : in_num[l];
    end
  end

  always_comb begin : div_step
    logic [DIFF_W:0] tmp;
    logic [DIFF_W:0] dif;
    logic            ge;
    for (int k = 0; k < NUM_WIDTH; k++) begin
      for (int l = 0; l < LANES; l++) begin
        tmp = {rem_r[k][l], nq_r[k][l][NUM_WIDTH-1]};
        dif = tmp - {1'b0, den_r[k]};
        ge  = (tmp >= {1'b0, den_r[k]});
        rem_nxt[k][l] = ge ? dif[DIFF_W-1:0] : tmp[DIFF_W-1:0];
        nq_nxt[k][l]  = {nq_r[k][l][NUM_WIDTH-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      den_r[0]  <= den_mag;
      side_r[0] <= in_side;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= '0;
        nq_r[0][l]  <= num_mag[l];
        sg_r[0][l]  <= in_num[l][NUM_WIDTH-1] ^ in_den[DIFF_W-1];
      end
    end
    for (int k = 1; k <= NUM_WIDTH; k++) begin
      if (adv[k]) begin
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= rem_nxt[k-1][l];
          nq_r[k][l]  <= nq_nxt[k-1][l];
          sg_r[k][l]  <= sg_r[k-1][l];
        end
      end
    end
    if (adv[LAST]) begin
      side_r[LAST] <= side_r[LAST-1];
      for (int l = 0; l < LANES; l++) begin
        quot_r[l] <= sg_r[NUM_WIDTH][l] ? (~nq_r[NUM_WIDTH][l][VALUE_WIDTH-1:0] + 1'b1)
                                        : nq_r[NUM_WIDTH][l][VALUE_WIDTH-1:0];
      end
    end
  end

  `BI_ASSERT_IMPL(a_rem_below_den, v_r[NUM_WIDTH] && (den_r[NUM_WIDTH] != '0), rem_r[NUM_WIDTH][0] < den_r[NUM_WIDTH])
  `BI_ASSERT_NEXT(a_out_held, v_r[LAST] && !out_ready, v_r[LAST])
  `BI_ASSERT_NEXT(a_stage_frozen, v_r[1] && !adv[1], $stable(side_r[1]) && v_r[1])

endmodule

// ----- rtl/bi_ymul.sv -----
// ----------------------------------------------------------------------------
// bi_ymul
// row midpoints, their difference and the second-axis numerator, three stages
// ----------------------------------------------------------------------------
module bi_ymul #(
  parameter int VALUE_WIDTH = 16,
  parameter int NUM_WIDTH   = 34
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0][VALUE_WIDTH-1:0]       in_quot,
  input  logic [VALUE_WIDTH-1:0]            in_base_a,
  input  logic [VALUE_WIDTH-1:0]            in_base_b,
  input  bi_pkg::diff_t                     in_dp_y,
  input  bi_pkg::diff_t                     in_span_y,
  input  logic                              in_zero,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [NUM_WIDTH-1:0]              out_num,
  output bi_pkg::diff_t                     out_span_y,
  output logic [VALUE_WIDTH-1:0]            out_mid_a,
  output logic                              out_zero
);
  import bi_pkg::*;

  logic [2:0] v_r;
  logic [3:0] adv;

  logic [VALUE_WIDTH-1:0]       mida_r, midb_r;
  diff_t                        dpy_r, spy_r;
  logic                         zero_r;

  logic signed [VALUE_WIDTH:0]  dm_r;
  logic [VALUE_WIDTH-1:0]       mida1_r;
  diff_t                        dpy1_r, spy1_r;
  logic                         zero1_r;

  logic signed [NUM_WIDTH-1:0]  num_r;
  logic [VALUE_WIDTH-1:0]       mida2_r;
  diff_t                        spy2_r;
  logic                         zero2_r;

  always_comb begin
    adv[3] = out_ready;
    for (int k = 2; k >= 0; k--) begin
      adv[k] = ~v_r[k] | adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mida_r <= in_base_a + in_quot[0];
      midb_r <= in_base_b + in_quot[1];
      dpy_r  <= in_dp_y;
      spy_r  <= in_span_y;
      zero_r <= in_zero;
    end
    if (adv[1]) begin
      dm_r    <= {midb_r[VALUE_WIDTH-1], midb_r} - {mida_r[VALUE_WIDTH-1], mida_r};
      mida1_r <= mida_r;
      dpy1_r  <= dpy_r;
      spy1_r  <= spy_r;
      zero1_r <= zero_r;
    end
    if (adv[2]) begin
      num_r   <= dpy1_r * dm_r;
      mida2_r <= mida1_r;
      spy2_r  <= spy1_r;
      zero2_r <= zero1_r;
    end
  end

  assign out_valid  = v_r[2];
  assign out_num    = num_r;
  assign out_span_y = spy2_r;
  assign out_mid_a  = mida2_r;
  assign out_zero   = zero2_r;

endmodule

// ----- rtl/bilinear_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// bilinear_interpolator_unit
// integer bilinear interpolation over one map cell per item
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with the query point, the cell edges and
// the four corner values of one cell, all two's complement
// result channel: out_valid/out_ready with out_interpolated (wrapped to
// VALUE_WIDTH bits) and out_zero_span, set with a zero result when either
// cell span is zero
// throughput: one item per cycle while no stall holds the output, with the two
// first-axis divisions sharing one bit-per-stage divider pipeline and the
// second-axis division in another; each divider has VALUE_WIDTH + 20 stages
// reset: clears every stage valid bit; the pipeline comes up empty and ready
// stall: a held result freezes only the full stages behind it, empty stages
// keep filling, so in_ready drops only once every stage holds an item
// ----------------------------------------------------------------------------
module bilinear_interpolator_unit #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bi_pkg::coord_t                in_query_x,
  input  bi_pkg::coord_t                in_query_y,
  input  bi_pkg::coord_t                in_cell_x_low,
  input  bi_pkg::coord_t                in_cell_x_high,
  input  bi_pkg::coord_t                in_cell_y_low,
  input  bi_pkg::coord_t                in_cell_y_high,
  input  logic signed [VALUE_WIDTH-1:0] in_corner_a_low,
  input  logic signed [VALUE_WIDTH-1:0] in_corner_a_high,
  input  logic signed [VALUE_WIDTH-1:0] in_corner_b_low,
  input  logic signed [VALUE_WIDTH-1:0] in_corner_b_high,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_interpolated,
  output logic                          out_zero_span
);
  import bi_pkg::*;

  localparam int NUM_WIDTH = VALUE_WIDTH + DIFF_W + 1;
  localparam int SIDE_X    = 2 * VALUE_WIDTH + 2 * DIFF_W + 1;
  localparam int SIDE_Y    = VALUE_WIDTH + 1;

  logic                         p_valid, p_ready;
  logic [1:0][NUM_WIDTH-1:0]    p_num;
  diff_t                        p_span_x, p_dp_y, p_span_y;
  logic [VALUE_WIDTH-1:0]       p_base_a, p_base_b;
  logic                         p_zero;

  logic                         xd_valid, xd_ready;
  logic [1:0][VALUE_WIDTH-1:0]  xd_quot;
  logic [SIDE_X-1:0]            xd_side;
  logic [VALUE_WIDTH-1:0]       xd_base_a, xd_base_b;
  diff_t                        xd_dp_y, xd_span_y;
  logic                         xd_zero;

  logic                         ym_valid, ym_ready;
  logic [NUM_WIDTH-1:0]         ym_num;
  diff_t                        ym_span_y;
  logic [VALUE_WIDTH-1:0]       ym_mid_a;
  logic                         ym_zero;

  logic                         yd_valid, yd_ready;
  logic [0:0][VALUE_WIDTH-1:0]  yd_quot;
  logic [SIDE_Y-1:0]            yd_side;

  logic                         out_valid_r;
  logic [VALUE_WIDTH-1:0]       out_value_r;
  logic                         out_zero_r;

  bi_prep #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_WIDTH   (NUM_WIDTH)
  ) u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_query_x       (in_query_x),
    .in_query_y       (in_query_y),
    .in_cell_x_low    (in_cell_x_low),
    .in_cell_x_high   (in_cell_x_high),
    .in_cell_y_low    (in_cell_y_low),
    .in_cell_y_high   (in_cell_y_high),
    .in_corner_a_low  (in_corner_a_low),
    .in_corner_a_high (in_corner_a_high),
    .in_corner_b_low  (in_corner_b_low),
    .in_corner_b_high (in_corner_b_high),
    .out_valid        (p_valid),
    .out_ready        (p_ready),
    .out_num          (p_num),
    .out_span_x       (p_span_x),
    .out_dp_y         (p_dp_y),
    .out_span_y       (p_span_y),
    .out_base_a       (p_base_a),
    .out_base_b       (p_base_b),
    .out_zero         (p_zero)
  );

  bi_div #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_WIDTH   (NUM_WIDTH),
    .LANES       (2),
    .SIDE_WIDTH  (SIDE_X)
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_num    (p_num),
    .in_den    (p_span_x),
    .in_side   ({p_base_a, p_base_b, p_dp_y, p_span_y, p_zero}),
    .out_valid (xd_valid),
    .out_ready (xd_ready),
    .out_quot  (xd_quot),
    .out_side  (xd_side)
  );

  assign {xd_base_a, xd_base_b, xd_dp_y, xd_span_y, xd_zero} = xd_side;

  bi_ymul #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_WIDTH   (NUM_WIDTH)
  ) u_ymul (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (xd_valid),
    .in_ready   (xd_ready),
    .in_quot    (xd_quot),
    .in_base_a  (xd_base_a),
    .in_base_b  (xd_base_b),
    .in_dp_y    (xd_dp_y),
    .in_span_y  (xd_span_y),
    .in_zero    (xd_zero),
    .out_valid  (ym_valid),
    .out_ready  (ym_ready),
    .out_num    (ym_num),
    .out_span_y (ym_span_y),
    .out_mid_a  (ym_mid_a),
    .out_zero   (ym_zero)
  );

  bi_div #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_WIDTH   (NUM_WIDTH),
    .LANES       (1),
    .SIDE_WIDTH  (SIDE_Y)
  ) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ym_valid),
    .in_ready  (ym_ready),
    .in_num    (ym_num),
    .in_den    (ym_span_y),
    .in_side   ({ym_mid_a, ym_zero}),
    .out_valid (yd_valid),
    .out_ready (yd_ready),
    .out_quot  (yd_quot),
    .out_side  (yd_side)
  );

  assign yd_ready = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (yd_ready) begin
      out_valid_r <= yd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (yd_ready) begin
      out_zero_r  <= yd_side[0];
      out_value_r <= yd_side[0] ? '0 : (yd_side[SIDE_Y-1:1] + yd_quot[0]);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interpolated = out_value_r;
  assign out_zero_span    = out_zero_r;

endmodule
